// ----- design/pfc_pkg.sv -----
package pfc_pkg;

	typedef enum logic [2:0] {
		FMT_UNKNOWN = 3'd0,
		FMT_Y8      = 3'd1,
		FMT_RGB8    = 3'd2,
		FMT_RGBA8   = 3'd3,
		FMT_YFIX    = 3'd4,
		FMT_RGBFIX  = 3'd5,
		FMT_RGBAFIX = 3'd6
	} fmt_t;

	typedef enum logic [0:0] {
		REG_SOURCE_FORMAT = 1'b0,
		REG_TARGET_FORMAT = 1'b1
	} reg_index_t;

	// per-transaction control, decoded once at accept and carried down the pipe
	typedef struct packed {
		logic err;        // unknown target: pass through
		logic mask8;      // 8-bit source: drop high byte
		logic bcast;      // gray source: copy chan0 to chan1/chan2
		logic to_fix;     // u8 -> fixed on the way in
		logic luma_en;    // color -> gray
		logic to_u8;      // fixed -> u8 on the way out
		logic d8;         // 8-bit target
		logic alpha_fill; // target has alpha, source lacks it
		logic keep12;     // target carries chan1/chan2
		logic keep3;      // target carries chan3
	} ctrl_t;

	localparam logic [15:0] LUMA_R = 16'd19595;
	localparam logic [15:0] LUMA_G = 16'd38470;
	localparam logic [15:0] LUMA_B = 16'd7471;

	// fixed -> u8: floor(x * 25599 / (100 * 2^F)), 255 once the quotient reaches 25600
	localparam logic [14:0] F2U_SCALE     = 15'd25599;
	localparam int unsigned F2U_SAT       = 25600;
	// t / 100 as (t * ceil(2^31 / 100)) >> 31, exact for t below 2^15
	localparam logic [24:0] DIV100_MUL    = 25'd21474837;
	localparam int unsigned DIV100_SHIFT  = 31;

	function automatic logic fmt_known(fmt_t f);
		return f inside {[FMT_Y8:FMT_RGBAFIX]};
	endfunction

	function automatic logic fmt_is8(fmt_t f);
		return f inside {FMT_Y8, FMT_RGB8, FMT_RGBA8};
	endfunction

	function automatic logic [2:0] fmt_chans(fmt_t f);
		logic [2:0] n;
		case (f)
			FMT_Y8, FMT_YFIX:      n = 3'd1;
			FMT_RGB8, FMT_RGBFIX:  n = 3'd3;
			FMT_RGBA8, FMT_RGBAFIX: n = 3'd4;
			default:               n = 3'd0;
		endcase
		return n;
	endfunction

	function automatic ctrl_t decode(logic [2:0] src_code, logic [2:0] dst_code);
		ctrl_t c;
		fmt_t s;
		fmt_t d;
		logic [2:0] sn;
		logic [2:0] dn;
		logic s8;
		logic d8;
		logic to_gray;
		c = '0;
		s = fmt_t'(src_code);
		d = fmt_t'(dst_code);
		if (!fmt_known(d)) begin
			c.err    = 1'b1;
			c.keep12 = 1'b1;
			c.keep3  = 1'b1;
		end else begin
			if (!fmt_known(s))
				s = d;
			sn      = fmt_chans(s);
			dn      = fmt_chans(d);
			s8      = fmt_is8(s);
			d8      = fmt_is8(d);
			to_gray = (dn == 3'd1) && (sn != 3'd1);
			c.mask8      = s8;
			c.bcast      = (sn == 3'd1);
			c.to_fix     = s8 && (to_gray || !d8);
			c.luma_en    = to_gray;
			c.to_u8      = d8 && (to_gray || !s8);
			c.d8         = d8;
			c.alpha_fill = (dn == 3'd4) && (sn != 3'd4);
			c.keep12     = (dn != 3'd1);
			c.keep3      = (dn == 3'd4);
		end
		return c;
	endfunction

endpackage

// ----- design/pfc_u8_to_fix.sv -----
module pfc_u8_to_fix #(
	parameter int unsigned FRAC_BITS = 15
) (
	input  logic        clk,
	input  logic [7:0]  v,
	output logic [15:0] q
);
	// round(v * 2^F / 255) = (v * 2^F + 127) / 255, divide by reciprocal
	localparam int unsigned NW = FRAC_BITS + 8;
	localparam int unsigned SH = NW + 16;
	localparam int unsigned PW = SH + 16;
	localparam logic [PW-1:0] RECIP = ((PW'(1) << SH) + PW'(254)) / PW'(255);

	logic [NW-1:0] num;
	logic [PW-1:0] prod_s2;

	// low F bits of v * 2^F are zero, so the +127 is an OR
	assign num = {v, {FRAC_BITS{1'b0}}} | NW'(7'd127);

	always_ff @(posedge clk) begin
		prod_s2 <= PW'(num) * RECIP;
	end

	assign q = prod_s2[SH +: 16];

endmodule

// ----- design/pfc_luma.sv -----
module pfc_luma (
	input  logic        clk,
	input  logic [15:0] r,
	input  logic [15:0] g,
	input  logic [15:0] b,
	output logic [15:0] y
);
	import pfc_pkg::*;

	logic [31:0] pr_s4;
	logic [31:0] pg_s4;
	logic [31:0] pb_s4;
	logic [33:0] sum;
	logic [15:0] y_s5;

	always_ff @(posedge clk) begin
		pr_s4 <= 32'(r) * 32'(LUMA_R);
		pg_s4 <= 32'(g) * 32'(LUMA_G);
		pb_s4 <= 32'(b) * 32'(LUMA_B);
	end

	// coefficients sum to 2^16, so the total stays below 2^32
	assign sum = 34'(pr_s4) + 34'(pg_s4) + 34'(pb_s4);

	always_ff @(posedge clk) begin
		y_s5 <= sum[31:16];
	end

	assign y = y_s5;

endmodule

// ----- design/pfc_fix_to_u8.sv -----
module pfc_fix_to_u8 #(
	parameter int unsigned FRAC_BITS = 15
) (
	input  logic        clk,
	input  logic [15:0] x,
	output logic [7:0]  q
);
	import pfc_pkg::*;

	localparam int unsigned TW = 31 - FRAC_BITS;

	logic [30:0]   m_s6;
	logic [TW-1:0] t;
	logic          sat;
	logic [39:0]   prod_s7;
	logic          sat_s7;

	always_ff @(posedge clk) begin
		m_s6 <= 31'(x) * 31'(F2U_SCALE);
	end

	assign t   = m_s6[30:FRAC_BITS];
	assign sat = (t >= TW'(F2U_SAT));

	// below the saturation point t fits in 15 bits
	always_ff @(posedge clk) begin
		prod_s7 <= 40'(t[14:0]) * 40'(DIV100_MUL);
		sat_s7  <= sat;
	end

	assign q = sat_s7 ? 8'hFF : prod_s7[DIV100_SHIFT +: 8];

endmodule

// ----- design/pixel_format_converter.sv -----
// Channel   Dir  Handshake          Payload
// --------  ---  -----------------  -------------------------------------------
// pixel in  in   start, busy        chan0_in..chan3_in (16 b each)
// pixel out out  done (1-cycle)     chan0_out..chan3_out (16 b), format_error
// config    in   cfg_we             cfg_index (0 source, 1 target), cfg_data
//
// One pixel per clock; busy is always low, so start may be held every cycle.
// From accept to done a pixel passes the input register, u8->fixed
// multiply, select, luma multiply, luma sum, fixed->u8 multiply, divide by
// 100 and output register. arst_n clears the format registers and valid bits.
// The receiver cannot stall; results are shown for exactly one cycle.
module pixel_format_converter #(
	parameter int unsigned FRAC_BITS = 15
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [2:0]  cfg_data,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] chan0_in,
	input  logic [15:0] chan1_in,
	input  logic [15:0] chan2_in,
	input  logic [15:0] chan3_in,
	output logic        done,
	output logic [15:0] chan0_out,
	output logic [15:0] chan1_out,
	output logic [15:0] chan2_out,
	output logic [15:0] chan3_out,
	output logic        format_error
);
	import pfc_pkg::*;

	localparam logic [15:0] FIX_ONE = 16'(1) << FRAC_BITS;

	logic [2:0] source_format_q;
	logic [2:0] target_format_q;

	ctrl_t            ctrl_in;
	logic [3:0][15:0] chan_in;
	logic             accept;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;
	ctrl_t ctrl_s1, ctrl_s2, ctrl_s3, ctrl_s4, ctrl_s5, ctrl_s6, ctrl_s7;
	logic [3:0][15:0] chan_s1, chan_s2, chan_s3, chan_s4, chan_s5, chan_s6, chan_s7;

	logic [3:0][15:0] u2f_q;
	logic [15:0]      luma_y;
	logic [3:0][15:0] sel_s5;
	logic [3:0][7:0]  f2u_q;
	logic [3:0][15:0] res;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_format_q <= 3'd0;
			target_format_q <= 3'd0;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_SOURCE_FORMAT: source_format_q <= cfg_data;
				REG_TARGET_FORMAT: target_format_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		ctrl_in = decode(source_format_q, target_format_q);
		chan_in = {chan3_in, chan2_in, chan1_in, chan0_in};
		if (ctrl_in.mask8) begin
			for (int i = 0; i < 4; i++)
				chan_in[i] = {8'd0, chan_in[i][7:0]};
		end
		if (ctrl_in.bcast) begin
			chan_in[1] = chan_in[0];
			chan_in[2] = chan_in[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			done     <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
			done     <= valid_s7;
		end
	end

	for (genvar i = 0; i < 4; i++) begin : g_u2f
		pfc_u8_to_fix #(.FRAC_BITS(FRAC_BITS)) u_u2f (
			.clk (clk),
			.v   (chan_s1[i][7:0]),
			.q   (u2f_q[i])
		);
	end

	pfc_luma u_luma (
		.clk (clk),
		.r   (chan_s3[0]),
		.g   (chan_s3[1]),
		.b   (chan_s3[2]),
		.y   (luma_y)
	);

	always_comb begin
		sel_s5 = chan_s5;
		if (ctrl_s5.luma_en)
			sel_s5[0] = luma_y;
	end

	for (genvar i = 0; i < 4; i++) begin : g_f2u
		pfc_fix_to_u8 #(.FRAC_BITS(FRAC_BITS)) u_f2u (
			.clk (clk),
			.x   (sel_s5[i]),
			.q   (f2u_q[i])
		);
	end

	always_ff @(posedge clk) begin
		ctrl_s1 <= ctrl_in;
		chan_s1 <= chan_in;
		ctrl_s2 <= ctrl_s1;
		chan_s2 <= chan_s1;
		ctrl_s3 <= ctrl_s2;
		for (int i = 0; i < 4; i++)
			chan_s3[i] <= ctrl_s2.to_fix ? u2f_q[i] : chan_s2[i];
		ctrl_s4 <= ctrl_s3;
		chan_s4 <= chan_s3;
		ctrl_s5 <= ctrl_s4;
		chan_s5 <= chan_s4;
		ctrl_s6 <= ctrl_s5;
		chan_s6 <= sel_s5;
		ctrl_s7 <= ctrl_s6;
		chan_s7 <= chan_s6;
	end

	always_comb begin
		for (int i = 0; i < 4; i++)
			res[i] = ctrl_s7.to_u8 ? {8'd0, f2u_q[i]} : chan_s7[i];
		if (ctrl_s7.alpha_fill)
			res[3] = ctrl_s7.d8 ? 16'd255 : FIX_ONE;
		if (!ctrl_s7.keep12) begin
			res[1] = 16'd0;
			res[2] = 16'd0;
		end
		if (!ctrl_s7.keep3)
			res[3] = 16'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			format_error <= 1'b0;
		else
			format_error <= valid_s7 && ctrl_s7.err;
	end

	always_ff @(posedge clk) begin
		chan0_out <= res[0];
		chan1_out <= res[1];
		chan2_out <= res[2];
		chan3_out <= res[3];
	end

endmodule

// ----- design/pfc_checker.sv -----
module pfc_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic format_error
);
	localparam int unsigned LATENCY = 8;

	// every accepted transaction comes out a fixed number of cycles later
	a_accept_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("accepted transaction produced no result");

	// and nothing comes out that was not accepted
	a_done_from_accept: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without a matching accepted transaction");

	a_error_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		format_error |-> done)
		else $error("format_error outside a result cycle");

endmodule

bind pixel_format_converter pfc_checker u_pfc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.format_error (format_error)
);

// ----- tb/testbench.sv -----
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import pfc_pkg::*;

	localparam int unsigned FRAC        = 15;
	localparam longint      FIX_ONE     = 64'd1 << FRAC;
	localparam int unsigned CYCLE_LIMIT = 100000;
	localparam int unsigned DRAIN_WAIT  = 16;

	typedef struct packed {
		logic             err;
		logic [3:0][15:0] ch;
	} pixel_t;

	typedef struct packed {
		fmt_t             src;
		fmt_t             dst;
		logic [3:0][15:0] px;
		logic             typed;
		pixel_t           want;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [0:0]  cfg_index = REG_SOURCE_FORMAT;
	logic [2:0]  cfg_data = '0;
	logic        start = 1'b0;
	logic        busy;
	logic [15:0] chan0_in = '0;
	logic [15:0] chan1_in = '0;
	logic [15:0] chan2_in = '0;
	logic [15:0] chan3_in = '0;
	logic        done;
	logic [15:0] chan0_out;
	logic [15:0] chan1_out;
	logic [15:0] chan2_out;
	logic [15:0] chan3_out;
	logic        format_error;

	pixel_t      pending_px[$];
	stim_row_t   directed_rows[$];
	fmt_t        cur_src = FMT_UNKNOWN;
	fmt_t        cur_dst = FMT_UNKNOWN;
	int          burst_left = 0;
	int          mismatches = 0;
	int unsigned cycles = 0;

	pixel_format_converter #(.FRAC_BITS(FRAC)) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.start       (start),
		.busy        (busy),
		.chan0_in    (chan0_in),
		.chan1_in    (chan1_in),
		.chan2_in    (chan2_in),
		.chan3_in    (chan3_in),
		.done        (done),
		.chan0_out   (chan0_out),
		.chan1_out   (chan1_out),
		.chan2_out   (chan2_out),
		.chan3_out   (chan3_out),
		.format_error(format_error)
	);

	always #10 clk = ~clk;

	function automatic bit is_known(fmt_t f);
		return f != FMT_UNKNOWN && f <= FMT_RGBAFIX;
	endfunction

	function automatic bit is_byte_fmt(fmt_t f);
		return f == FMT_Y8 || f == FMT_RGB8 || f == FMT_RGBA8;
	endfunction

	function automatic int chan_count(fmt_t f);
		case (f)
			FMT_Y8, FMT_YFIX:       return 1;
			FMT_RGB8, FMT_RGBFIX:   return 3;
			default:                return 4;
		endcase
	endfunction

	// round(v * 2^F / 255)
	function automatic logic [63:0] byte_to_fix(logic [7:0] v);
		return ((64'(v) << FRAC) + 64'd127) / 64'd255;
	endfunction

	// floor(x * 255.99 / 2^F), clipped to 255
	function automatic logic [63:0] fix_to_byte(logic [15:0] x);
		logic [63:0] r;
		r = (64'(x) * 64'd25599) / (64'd100 * FIX_ONE);
		return (r > 64'd255) ? 64'd255 : r;
	endfunction

	function automatic pixel_t convert_pixel(fmt_t src, fmt_t dst, logic [3:0][15:0] px);
		pixel_t      res;
		logic [63:0] c [4];
		int          sn;
		int          dn;
		bit          s8;
		bit          d8;
		res = '0;
		if (!is_known(dst)) begin
			res.err = 1'b1;
			res.ch  = px;
			return res;
		end
		if (!is_known(src))
			src = dst;
		sn = chan_count(src);
		dn = chan_count(dst);
		s8 = is_byte_fmt(src);
		d8 = is_byte_fmt(dst);
		for (int i = 0; i < 4; i++)
			c[i] = s8 ? 64'(px[i][7:0]) : 64'(px[i]);
		// color to gray is always done on fixed-point channels
		if (dn == 1 && sn > 1) begin
			if (s8)
				for (int i = 0; i < 3; i++)
					c[i] = byte_to_fix(c[i][7:0]);
			c[0] = (64'd19595 * c[0] + 64'd38470 * c[1] + 64'd7471 * c[2]) >> 16;
			s8 = 1'b0;
			sn = 1;
		end
		if (sn == 1) begin
			c[1] = c[0];
			c[2] = c[0];
		end
		if (s8 != d8)
			for (int i = 0; i < 4; i++)
				c[i] = d8 ? fix_to_byte(c[i][15:0]) : byte_to_fix(c[i][7:0]);
		if (dn == 4 && sn != 4)
			c[3] = d8 ? 64'd255 : FIX_ONE;
		for (int i = 0; i < 4; i++)
			res.ch[i] = (i < dn) ? c[i][15:0] : 16'h0000;
		return res;
	endfunction

	function automatic logic [15:0] rand_chan();
		case ($urandom_range(0, 5))
			0:       return 16'h0000;
			1:       return 16'hffff;
			2:       return 16'($urandom_range(0, FIX_ONE));
			3:       return 16'($urandom);
			4:       return {8'($urandom), 8'($urandom_range(0, 255))};
			default: begin
				case ($urandom_range(0, 3))
					0:       return 16'(FIX_ONE);
					1:       return 16'h00ff;
					2:       return 16'h7fff;
					default: return 16'(FIX_ONE + 1);
				endcase
			end
		endcase
	endfunction

	task automatic add_case(fmt_t s, fmt_t d, logic [3:0][15:0] px, logic typed,
			logic [3:0][15:0] want_ch, logic want_err);
		stim_row_t r;
		r.src      = s;
		r.dst      = d;
		r.px       = px;
		r.typed    = typed;
		r.want.ch  = want_ch;
		r.want.err = want_err;
		directed_rows.push_back(r);
	endtask

	// formats only change with the pipe empty
	task automatic set_formats(fmt_t s, fmt_t d);
		start <= 1'b0;
		while (pending_px.size() != 0)
			@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_SOURCE_FORMAT;
		cfg_data  <= s;
		@(posedge clk);
		cfg_index <= REG_TARGET_FORMAT;
		cfg_data  <= d;
		@(posedge clk);
		cfg_we  <= 1'b0;
		cur_src = s;
		cur_dst = d;
		burst_left = 0;
	endtask

	task automatic send_pixel(logic [3:0][15:0] px, logic typed, pixel_t want);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		start    <= 1'b1;
		chan0_in <= px[0];
		chan1_in <= px[1];
		chan2_in <= px[2];
		chan3_in <= px[3];
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_px.push_back(typed ? want : convert_pixel(cur_src, cur_dst, px));
		burst_left--;
	endtask

	always @(posedge clk) begin : check_results
		pixel_t           want;
		logic [3:0][15:0] got;
		if (done) begin
			got = {chan3_out, chan2_out, chan1_out, chan0_out};
			if (pending_px.size() == 0) begin
				$error("result with no pixel pending");
				mismatches++;
			end else begin
				want = pending_px.pop_front();
				for (int i = 0; i < 4; i++)
					if (got[i] !== want.ch[i]) begin
						$error("chan%0d_out: expected %h, got %h", i, want.ch[i], got[i]);
						mismatches++;
					end
				if (format_error !== want.err) begin
					$error("format_error: expected %b, got %b", want.err, format_error);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		logic [3:0][15:0] px;
		int               n;
		// reset state: both formats unknown, pass through with error
		add_case(FMT_UNKNOWN, FMT_UNKNOWN, 64'habcd_1234_0000_ffff, 1,
			64'habcd_1234_0000_ffff, 1);
		add_case(FMT_Y8, FMT_YFIX, 64'h1111_2222_3333_aaff, 1, 64'h0000_0000_0000_8000, 0);
		add_case(FMT_Y8, FMT_YFIX, 64'h0000_0000_0000_0000, 1, 64'h0, 0);
		add_case(FMT_YFIX, FMT_Y8, 64'h0000_0000_0000_8000, 1, 64'h0000_0000_0000_00ff, 0);
		add_case(FMT_YFIX, FMT_Y8, 64'hffff_ffff_ffff_ffff, 1, 64'h0000_0000_0000_00ff, 0);
		add_case(FMT_YFIX, FMT_Y8, 64'h0000_0000_0000_3c2a, 0, 64'h0, 0);
		add_case(FMT_RGBAFIX, FMT_RGBA8, 64'hffff_ffff_ffff_ffff, 1,
			64'h00ff_00ff_00ff_00ff, 0);
		add_case(FMT_RGBA8, FMT_RGBAFIX, 64'hff00_7aff_01ff_00ff, 1,
			64'h0000_8000_8000_8000, 0);
		add_case(FMT_RGBA8, FMT_RGBA8, 64'h12ab_34cd_56ef_7801, 1,
			64'h00ab_00cd_00ef_0001, 0);
		add_case(FMT_Y8, FMT_RGBA8, 64'h5555_6666_7777_1280, 1, 64'h00ff_0080_0080_0080, 0);
		add_case(FMT_YFIX, FMT_RGBAFIX, 64'h0_0_0_1234, 1, 64'h8000_1234_1234_1234, 0);
		add_case(FMT_RGB8, FMT_Y8, 64'h0000_00ff_00ff_00ff, 1, 64'h0000_0000_0000_00ff, 0);
		add_case(FMT_RGB8, FMT_Y8, 64'h9999_0040_0080_00c0, 0, 64'h0, 0);
		add_case(FMT_RGBFIX, FMT_YFIX, 64'h0000_1000_7fff_8000, 0, 64'h0, 0);
		add_case(FMT_RGBA8, FMT_Y8, 64'h00ff_0013_00f0_0077, 0, 64'h0, 0);
		add_case(FMT_RGBAFIX, FMT_Y8, 64'h8000_ffff_0000_4000, 0, 64'h0, 0);
		// unknown source: input taken as already in the target format
		add_case(FMT_UNKNOWN, FMT_RGB8, 64'h7777_56ef_34cd_12ab, 1,
			64'h0000_00ef_00cd_00ab, 0);
		// unknown target with a known source still passes through
		add_case(FMT_RGB8, FMT_UNKNOWN, 64'h7777_56ef_34cd_12ab, 1,
			64'h7777_56ef_34cd_12ab, 1);
		add_case(FMT_RGB8, FMT_RGBAFIX, 64'h1234_00ff_0080_0001, 0, 64'h0, 0);
		add_case(FMT_Y8, FMT_RGB8, 64'h0_0_0_ff7f, 0, 64'h0, 0);
		add_case(FMT_RGBFIX, FMT_RGB8, 64'h0_ffff_4000_0100, 0, 64'h0, 0);
		add_case(FMT_YFIX, FMT_RGB8, 64'h0_0_0_9000, 0, 64'h0, 0);
		add_case(FMT_RGBAFIX, FMT_RGB8, 64'h8000_2000_6000_7fff, 0, 64'h0, 0);
		add_case(FMT_RGB8, FMT_YFIX, 64'h0_00ff_0000_0000, 0, 64'h0, 0);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[k]) begin
			if (directed_rows[k].src != cur_src || directed_rows[k].dst != cur_dst)
				set_formats(directed_rows[k].src, directed_rows[k].dst);
			send_pixel(directed_rows[k].px, directed_rows[k].typed, directed_rows[k].want);
		end

		// every source/target pair, random pixels in each
		for (int s = 0; s <= 6; s++)
			for (int d = 0; d <= 6; d++) begin
				set_formats(fmt_t'(s), fmt_t'(d));
				n = $urandom_range(8, 16);
				repeat (n) begin
					for (int i = 0; i < 4; i++)
						px[i] = rand_chan();
					send_pixel(px, 1'b0, '0);
				end
			end

		start <= 1'b0;
		while (pending_px.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
